// ===== hdl/bms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded multiset table package
// Opcodes, field widths and default sizes shared by the table modules.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int CAPACITY_DEFAULT    = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int OPCODE_W  = 2;
    localparam int ENTRY_W   = 32;
    localparam int COUNT_FW  = 5;
    localparam int RESULT_W  = 1 + COUNT_FW + 1 + COUNT_FW + 1;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int S_TDATA_W = ENTRY_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

endpackage

// ===== hdl/bms_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded multiset table entry store
// Single write port, single registered read port entry memory.
// ----------------------------------------------------------------------------
module bms_store #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/bounded_multiset_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded multiset table
// Fixed-capacity bag of values with add, remove, clear and query operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers carry the opcode on s_tuser and the value on s_tdata.
//   Each produces one result transfer on m_tdata describing the bag after
//   the operation: accepted flag, frequency of the value, presence, entry
//   count and empty flag.
//   One comparator walks the N held entries through the store's single
//   read port, one per cycle, to count matches, locate the first match and
//   pick up the last entry; an update step then updates the store.
//   A clear, or any operation while the bag is empty, skips the scan and
//   goes straight to the update step.
//   s_tready is high only while the block is idle.
//   A waiting result sits in the output register; while the receiver stalls
//   the block finishes the next item's scan, then holds in its update step.
//   Reset empties the bag and drops any pending result; the store contents
//   are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module bounded_multiset_table_top #(
    parameter int CAPACITY    = bms_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = bms_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_value[31:0]
    input  logic [bms_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [bms_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // accepted[0], frequency[5:1], present[6], item_count[11:7],
    // is_empty[12], zero[15:13]
    output logic [bms_pkg::M_TDATA_W-1:0]  m_tdata
);

    import bms_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = M_TDATA_W - RESULT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    state_t                 state_reg,     state_next;
    op_t                    op_reg,        op_next;
    logic [VALUE_WIDTH-1:0] value_reg,     value_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic [IDX_W-1:0]       idx_reg,       idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg,   cmp_idx_next;
    logic [CNT_W-1:0]       match_reg,     match_next;
    logic                   found_reg,     found_next;
    logic [IDX_W-1:0]       first_reg,     first_next;
    logic [VALUE_WIDTH-1:0] last_reg,      last_next;
    logic                   m_tvalid_reg,  m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,   m_tdata_next;

    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;
    logic [VALUE_WIDTH-1:0] mem_rd_data;

    logic                   upd_ok;
    logic [CNT_W-1:0]       upd_freq;
    logic [CNT_W-1:0]       upd_count;
    logic [CNT_W-1:0]       last_pos;

    bms_store #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    assign last_pos = count_reg - CNT_W'(1);

    always_comb begin
        upd_ok      = 1'b1;
        upd_freq    = match_reg;
        upd_count   = count_reg;
        mem_wr_addr = first_reg;
        mem_wr_data = last_reg;
        case (op_reg)
            OP_ADD: begin
                mem_wr_addr = count_reg[IDX_W-1:0];
                mem_wr_data = value_reg;
                if (count_reg < CNT_W'(CAPACITY)) begin
                    upd_freq  = match_reg + CNT_W'(1);
                    upd_count = count_reg + CNT_W'(1);
                end else begin
                    upd_ok = 1'b0;
                end
            end
            OP_REMOVE: begin
                if (found_reg) begin
                    upd_freq  = match_reg - CNT_W'(1);
                    upd_count = last_pos;
                end else begin
                    upd_ok = 1'b0;
                end
            end
            OP_CLEAR: begin
                upd_freq  = '0;
                upd_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        match_next     = match_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mem_wr_en      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cmp_valid_reg) begin
            if (mem_rd_data == value_reg) begin
                match_next = match_reg + CNT_W'(1);
                if (!found_reg) begin
                    found_next = 1'b1;
                    first_next = cmp_idx_reg;
                end
            end
            if (CNT_W'(cmp_idx_reg) == last_pos) begin
                last_next = mem_rd_data;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    value_next = VALUE_WIDTH'(s_tdata[ENTRY_W-1:0]);
                    match_next = '0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    if (count_reg == '0 || op_t'(s_tuser) == OP_CLEAR) begin
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = idx_reg;
                if (CNT_W'(idx_reg) == last_pos) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!m_tvalid_reg || m_tready) begin
                    mem_wr_en     = upd_ok && (op_reg == OP_ADD || op_reg == OP_REMOVE);
                    count_next    = upd_count;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0),
                                     upd_count == '0,
                                     COUNT_FW'(upd_count),
                                     upd_freq != '0,
                                     COUNT_FW'(upd_freq),
                                     upd_ok};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        op_reg      <= op_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        match_reg   <= match_next;
        found_reg   <= found_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_match_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (match_reg <= count_reg))
        else $error("match count exceeds entry count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    a_result_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_UPDATE))
        else $error("result raised outside update step");

    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_UPDATE && !cmp_valid_reg))
        else $error("store written during scan");

endmodule
